[src/mfks_pkg.sv]
// Shared types, character codes and the signature table of the model file keyword scanner.
package mfks_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SKIP   = 2'd1,
		MODE_DIGITS = 2'd2
	} mode_t;

	typedef struct packed {
		logic        magic_ok;
		logic [15:0] token_total;
		logic [31:0] units_value;
	} result_t;

	localparam logic [31:0] UNITS_RESET = 32'd128;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_E_LOWER = 8'h65;

	// Four bytes before the final 'e' of the word Dense, oldest first.
	localparam logic [31:0] WORD_DENS  = {8'h44, 8'h65, 8'h6E, 8'h73};
	localparam logic [39:0] WORD_DENSE = {WORD_DENS, CH_E_LOWER};
	// The quoted units key without its closing quote, oldest first.
	localparam logic [47:0] WORD_UNITS = {CH_QUOTE, 8'h75, 8'h6E, 8'h69, 8'h74, 8'h73};

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] val;
		unique case (idx)
			3'd0: val = 8'h89;
			3'd1: val = 8'h48;
			3'd2: val = 8'h44;
			3'd3: val = 8'h46;
			3'd4: val = 8'h0D;
			3'd5: val = 8'h0A;
			3'd6: val = 8'h1A;
			3'd7: val = 8'h0A;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

[src/mfks_scan.sv]
// Scan state and combinational next-state logic of the model file keyword scanner.
module mfks_scan import mfks_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output result_t    result
);

	logic [55:0]           hist_q;
	logic [2:0]            fill_q;
	logic [3:0]            pos_q;
	logic                  match_q;
	logic [COUNT_BITS-1:0] cnt_q;
	mode_t                 mode_q;
	logic [31:0]           acc_q;
	logic [31:0]           kept_q;

	logic [2:0]            fill_n;
	logic [3:0]            pos_n;
	logic                  match_n;
	logic [COUNT_BITS-1:0] cnt_n;
	mode_t                 mode_n;
	logic [31:0]           acc_n;
	logic [31:0]           kept_n;
	logic [31:0]           kept_out;
	logic [31:0]           digit_val;
	logic [31:0]           cnt_ext;
	logic                  is_digit;
	logic                  is_delim;
	logic                  dense_hist;
	logic                  dense_end;
	logic                  units_key;
	logic                  cnt_inc;

	always_comb begin
		is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		digit_val = {28'd0, data_byte[3:0]};
		is_delim  = (data_byte == CH_QUOTE) || (data_byte == CH_NUL) ||
			(data_byte == CH_SPACE) || (data_byte == CH_COMMA) ||
			(data_byte == CH_NEWLINE) || (data_byte == CH_COLON);

		pos_n   = pos_q;
		match_n = match_q;
		if (!pos_q[3]) begin
			if (data_byte != sig_byte(pos_q[2:0])) begin
				match_n = 1'b0;
			end
			pos_n = pos_q + 4'd1;
		end

		dense_hist = (fill_q >= 3'd5) && (hist_q[39:0] == WORD_DENSE);
		dense_end  = last_byte && (fill_q >= 3'd4) && (hist_q[31:0] == WORD_DENS) &&
			(data_byte == CH_E_LOWER);
		units_key  = (fill_q >= 3'd6) && (hist_q[47:0] == WORD_UNITS) &&
			(data_byte == CH_QUOTE);

		cnt_inc = (is_delim && dense_hist) || dense_end;
		cnt_n   = cnt_q;
		if (cnt_inc && (cnt_q != {COUNT_BITS{1'b1}})) begin
			cnt_n = cnt_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
		end

		mode_n = MODE_IDLE;
		acc_n  = acc_q;
		kept_n = kept_q;
		unique case (mode_q)
			MODE_SKIP: begin
				if ((data_byte == CH_COLON) || (data_byte == CH_SPACE)) begin
					mode_n = MODE_SKIP;
				end else if (is_digit) begin
					acc_n  = digit_val;
					mode_n = MODE_DIGITS;
				end
			end
			MODE_DIGITS: begin
				if (is_digit) begin
					acc_n  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + digit_val;
					mode_n = MODE_DIGITS;
				end else if (acc_q != 32'd0) begin
					kept_n = acc_q;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		if (units_key) begin
			mode_n = MODE_SKIP;
			acc_n  = 32'd0;
		end

		kept_out = kept_n;
		if ((mode_n == MODE_DIGITS) && (acc_n != 32'd0)) begin
			kept_out = acc_n;
		end

		fill_n = (fill_q == 3'd7) ? fill_q : fill_q + 3'd1;

		cnt_ext = 32'(cnt_n);
		result.magic_ok    = match_n && pos_n[3];
		result.units_value = kept_out;
		if (cnt_ext == 32'd0) begin
			result.token_total = 16'd1;
		end else if (cnt_ext > {16'd0, COUNT_MAX}) begin
			result.token_total = COUNT_MAX;
		end else begin
			result.token_total = cnt_ext[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			match_q <= 1'b1;
			cnt_q   <= '0;
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			kept_q  <= UNITS_RESET;
		end else if (step) begin
			if (last_byte) begin
				hist_q  <= '0;
				fill_q  <= '0;
				pos_q   <= '0;
				match_q <= 1'b1;
				cnt_q   <= '0;
				mode_q  <= MODE_IDLE;
				acc_q   <= '0;
				kept_q  <= UNITS_RESET;
			end else begin
				hist_q  <= {hist_q[47:0], data_byte};
				fill_q  <= fill_n;
				pos_q   <= pos_n;
				match_q <= match_n;
				cnt_q   <= cnt_n;
				mode_q  <= mode_n;
				acc_q   <= acc_n;
				kept_q  <= kept_n;
			end
		end
	end

endmodule

[src/model_file_keyword_scanner_core.sv]
// Top level of the model file keyword scanner: input register, scan logic and result register.
// Each byte request passes an input register and is scanned from that register.
// A result is registered in the result register when the final byte is scanned from the input register.
// One byte request is accepted every cycle; only a stalled, unread result holds the input.
// Reset clears the scan state, sets the kept units to 128 and empties both registers.
module model_file_keyword_scanner_core import mfks_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // magic_ok, token_total[15:0], units_value[31:0], zero pad
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    result_q;
	result_t    result;
	logic       out_free;
	logic       step;

	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || step;

	mfks_scan #(
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, result_q.units_value, result_q.token_total, result_q.magic_ok};

endmodule

[sim/model_file_keyword_scanner_core_tb.sv]
// Self-checking testbench for the model file keyword scanner core.
module model_file_keyword_scanner_core_tb;
	import mfks_pkg::*;

	localparam logic [63:0] SIGNATURE = 64'h8948_4446_0D0A_1A0A;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	bit          idle_on = 1'b1;
	int          error_count = 0;
	int          bytes_sent = 0;
	int          files_sent = 0;
	int          results_seen = 0;
	int          top_count_seen = 0;

	result_t     expected_results[$];
	logic [7:0]  file_bytes[$];
	logic [7:0]  delimiters[6];

	logic [55:0] hist_bytes;
	int          hist_count;
	int          hdr_pos;
	logic        hdr_good;
	logic [15:0] dense_tokens;
	mode_t       num_mode;
	logic [31:0] num_acc;
	logic        num_has_digit;
	logic [31:0] units_kept;

	model_file_keyword_scanner_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		if (idle_on)
			m_tready <= ($urandom_range(99) >= 32);
		else
			m_tready <= 1'b1;
	end

	function automatic void clear_scan_state();
		hist_bytes    = '0;
		hist_count    = 0;
		hdr_pos       = 0;
		hdr_good      = 1'b1;
		dense_tokens  = '0;
		num_mode      = MODE_IDLE;
		num_acc       = '0;
		num_has_digit = 1'b0;
		units_kept    = UNITS_RESET;
	endfunction

	function automatic void bump_dense();
		if (dense_tokens != 16'hFFFF)
			dense_tokens = dense_tokens + 16'd1;
	endfunction

	function automatic void predict_scan_byte(input logic [7:0] b, input logic lst);
		logic    is_digit;
		result_t res;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		if (hdr_pos < 8) begin
			if (b != SIGNATURE[63 - 8 * hdr_pos -: 8])
				hdr_good = 1'b0;
			hdr_pos++;
		end
		if (b == CH_QUOTE || b == CH_NUL || b == CH_SPACE || b == CH_COMMA ||
				b == CH_NEWLINE || b == CH_COLON) begin
			if (hist_count >= 5 && hist_bytes[39:0] == "Dense")
				bump_dense();
		end
		case (num_mode)
			MODE_SKIP: begin
				if (b == CH_COLON || b == CH_SPACE) begin
				end else if (is_digit) begin
					num_acc       = {24'd0, b - CH_ZERO};
					num_has_digit = 1'b1;
					num_mode      = MODE_DIGITS;
				end else begin
					num_mode = MODE_IDLE;
				end
			end
			MODE_DIGITS: begin
				if (is_digit) begin
					num_acc = num_acc * 32'd10 + {24'd0, b - CH_ZERO};
				end else begin
					if (num_has_digit && num_acc != 0)
						units_kept = num_acc;
					num_mode = MODE_IDLE;
				end
			end
			default: num_mode = MODE_IDLE;
		endcase
		if (hist_count >= 6 && {hist_bytes[47:0], b} == "\"units\"") begin
			num_mode      = MODE_SKIP;
			num_acc       = '0;
			num_has_digit = 1'b0;
		end
		if (!lst) begin
			hist_bytes = {hist_bytes[47:0], b};
			if (hist_count < 7)
				hist_count++;
		end else begin
			if (hist_count >= 4 && {hist_bytes[31:0], b} == "Dense")
				bump_dense();
			if (num_mode == MODE_DIGITS && num_has_digit && num_acc != 0)
				units_kept = num_acc;
			res.magic_ok    = hdr_good && (hdr_pos >= 8);
			res.token_total = (dense_tokens == 0) ? 16'd1 : dense_tokens;
			res.units_value = units_kept;
			expected_results.push_back(res);
			clear_scan_state();
		end
	endfunction

	always @(posedge clk) begin
		result_t     want;
		logic        got_magic;
		logic [15:0] got_count;
		logic [31:0] got_units;
		if (arst_n && m_tvalid && m_tready) begin
			got_magic = m_tdata[0];
			got_count = m_tdata[16:1];
			got_units = m_tdata[48:17];
			results_seen++;
			if (got_count > top_count_seen)
				top_count_seen = got_count;
			if (expected_results.size() == 0) begin
				$error("Unexpected result: magic_ok %0d token_total %0d units_value %0d",
					got_magic, got_count, got_units);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (got_magic !== want.magic_ok) begin
					$error("magic_ok expected %0d actual %0d", want.magic_ok, got_magic);
					error_count++;
				end
				if (got_count !== want.token_total) begin
					$error("token_total expected %0d actual %0d", want.token_total, got_count);
					error_count++;
				end
				if (got_units !== want.units_value) begin
					$error("units_value expected %0d actual %0d", want.units_value, got_units);
					error_count++;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while (idle_on && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_scan_byte(b, lst);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file();
		int n;
		n = file_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], i == n - 1);
		files_sent++;
		file_bytes.delete();
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			file_bytes.push_back(s[i]);
	endfunction

	function automatic void push_signature(input bit corrupt);
		int         spot;
		logic [7:0] b;
		spot = $urandom_range(7);
		for (int i = 0; i < 8; i++) begin
			b = SIGNATURE[63 - 8 * i -: 8];
			if (corrupt && i == spot)
				b = b ^ (8'd1 << $urandom_range(7));
			file_bytes.push_back(b);
		end
	endfunction

	function automatic void push_digits(input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
	endfunction

	function automatic void push_segment();
		case ($urandom_range(7))
			0: begin
				push_text("Dense");
				file_bytes.push_back(delimiters[$urandom_range(5)]);
			end
			1: begin
				push_text("Dense");
				file_bytes.push_back(8'($urandom_range(255)));
			end
			2: begin
				push_text("\"units\"");
				repeat ($urandom_range(3))
					file_bytes.push_back($urandom_range(1) ? CH_COLON : CH_SPACE);
				push_digits($urandom_range(12));
				if ($urandom_range(3) != 0)
					file_bytes.push_back(8'($urandom_range(255)));
			end
			3: begin
				push_text("\"units\":");
				case ($urandom_range(2))
					0: push_text("4294967296");
					1: push_text("000");
					default: push_text("4294967295");
				endcase
			end
			4: begin
				if ($urandom_range(1))
					push_text("Dens");
				else
					push_text("\"unit");
			end
			5: repeat ($urandom_range(1, 4))
				file_bytes.push_back(8'($urandom_range(255)));
			6: file_bytes.push_back(delimiters[$urandom_range(5)]);
			default: begin
				if ($urandom_range(1))
					push_digits($urandom_range(1, 3));
				else
					file_bytes.push_back($urandom_range(1) ? CH_COLON : CH_SPACE);
			end
		endcase
	endfunction

	task automatic test_directed_cases();
		file_bytes.push_back(8'hFF);
		send_file();
		file_bytes.push_back(8'h00);
		send_file();
		push_text("Dense");
		send_file();
		push_signature(1'b0);
		push_text("Dense,\"units\": 42");
		send_file();
		push_signature(1'b1);
		push_text("\"units\"4294967296 ");
		send_file();
		push_text("\"units\"7 \"units\"x");
		send_file();
		push_text("\"units\"12\"units\"5");
		send_file();
		push_text("Dense\"Dense");
		file_bytes.push_back(CH_NUL);
		push_text("Dense Dense,Dense\nDense:Densex");
		send_file();
		push_signature(1'b0);
		push_text("\"units\"4294967295 ");
		send_file();
		wait_all_results();
	endtask

	task automatic test_random_files(input int byte_goal);
		int start_bytes;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < byte_goal) begin
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 12))
					file_bytes.push_back(8'($urandom_range(255)));
			end else begin
				if ($urandom_range(9) != 0)
					push_signature($urandom_range(9) == 0);
				repeat ($urandom_range(6))
					push_segment();
				if ($urandom_range(99) < 15)
					push_text("Dense");
			end
			if (file_bytes.size() == 0)
				file_bytes.push_back(8'($urandom_range(255)));
			send_file();
			if ($urandom_range(9) == 0)
				wait_all_results();
		end
		wait_all_results();
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		test_random_files(500);
		idle_on = 1'b1;
	endtask

	initial begin
		delimiters = '{CH_QUOTE, CH_NUL, CH_SPACE, CH_COMMA, CH_NEWLINE, CH_COLON};
		clear_scan_state();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_files(750);
		test_back_to_back();
		wait_all_results();
		repeat (10) @(posedge clk);
		$display("Scanned %0d files in %0d bytes with %0d results checked.",
			files_sent, bytes_sent, results_seen);
		$display("Highest token count reported was %0d.", top_count_seen);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
